@@ design/ilid_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_pkg
// Shared types and constants for the positional list block: operation and
// status codes, field widths and the command broadcast to the cell row.
// ----------------------------------------------------------------------------
package ilid_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W     = 32;
  localparam int POS_W      = 5;
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;
  localparam int TREE_GROUP = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Command seen by every cell in the cycle an item is accepted
  typedef struct packed {
    logic              ins;
    logic              del;
    logic              rd;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage

@@ design/indexed_list_insert_delete_get.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_get
// Read path: after its item is accepted, a result passes the cell tap
//   (loaded at the accepting edge), the group OR register and the final OR
//   register in turn.
// Throughput: one item per cycle while the result side is not stalled.
// Reset: clears the entry count and the pipeline valids; slot contents stay
//   undefined until written.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_get #(
  parameter int DEPTH = ilid_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [ilid_pkg::OP_W-1:0]     operation,
  input  logic [ilid_pkg::POS_W-1:0]    position,
  input  logic signed [ilid_pkg::DATA_W-1:0] item_value,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [ilid_pkg::ST_W-1:0]     status,
  output logic signed [ilid_pkg::DATA_W-1:0] read_value,
  output logic [ilid_pkg::POS_W-1:0]    entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > ilid_pkg::POS_W) ? CW : ilid_pkg::POS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic                  adv;
  logic                  accept;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [EW-1:0]         pos_ext;
  logic [EW-1:0]         cnt_ext;
  logic [EW-1:0]         cnt_next_ext;
  ilid_pkg::status_t     st_now;
  ilid_pkg::cmd_t        cmd;
  logic                  do_ins;
  logic                  do_del;
  logic                  do_rd;

  logic                  v1;
  logic                  v2;
  ilid_pkg::status_t     st1;
  ilid_pkg::status_t     st2;
  logic [ilid_pkg::POS_W-1:0] cnt1;
  logic [ilid_pkg::POS_W-1:0] cnt2;

  logic [DEPTH-1:0][ilid_pkg::DATA_W-1:0] vals;
  logic [DEPTH-1:0][ilid_pkg::DATA_W-1:0] taps;
  logic [ilid_pkg::DATA_W-1:0]            rd_data;

  // Move the whole pipeline unless a result waits on a stalled consumer
  assign adv       = !(rsp_valid && rsp_stall);
  assign req_stall = !adv;
  assign accept    = req_valid && adv;

  assign pos_ext = EW'(position);
  assign cnt_ext = EW'(count);

  // Check the operation against the current count
  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    do_rd  = 1'b0;
    st_now = ilid_pkg::ST_OK;
    unique case (ilid_pkg::op_t'(operation))
      ilid_pkg::OP_INSERT: begin
        if (pos_ext > cnt_ext) begin
          st_now = ilid_pkg::ST_BADPOS;
        end else if (count == FULL_CNT) begin
          st_now = ilid_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      ilid_pkg::OP_DELETE, ilid_pkg::OP_READ: begin
        if (count == '0) begin
          st_now = ilid_pkg::ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          st_now = ilid_pkg::ST_BADPOS;
        end else if (ilid_pkg::op_t'(operation) == ilid_pkg::OP_DELETE) begin
          do_del = 1'b1;
        end else begin
          do_rd = 1'b1;
        end
      end
      default: begin
        st_now = ilid_pkg::ST_BADPOS;
      end
    endcase
  end

  // Broadcast the command only for an accepted item
  always_comb begin
    cmd.ins   = accept && do_ins;
    cmd.del   = accept && do_del;
    cmd.rd    = accept && do_rd;
    cmd.value = item_value;
  end

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CW'(1);
    end else if (do_del) begin
      count_next = count - CW'(1);
    end
  end

  assign cnt_next_ext = EW'(count_next);

  // Row of slots
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ilid_pkg::DATA_W-1:0] lower;
    logic [ilid_pkg::DATA_W-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = item_value;
    end else begin : g_mid_lo
      assign lower = vals[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = vals[i];
    end else begin : g_mid_hi
      assign upper = vals[i+1];
    end

    ilid_cell #(
      .IDX (i),
      .PW  (EW)
    ) u_cell (
      .clk   (clk),
      .adv   (adv),
      .cmd   (cmd),
      .pos   (pos_ext),
      .lower (lower),
      .upper (upper),
      .value (vals[i]),
      .tap   (taps[i])
    );
  end

  ilid_or_tree #(
    .N (DEPTH)
  ) u_tree (
    .clk    (clk),
    .adv    (adv),
    .taps   (taps),
    .result (rd_data)
  );

  // Hold count and the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      if (accept) begin
        count <= count_next;
      end
      v1        <= accept;
      v2        <= v1;
      rsp_valid <= v2;
    end
  end

  // Carry status and count alongside the read path
  always_ff @(posedge clk) begin
    if (adv) begin
      st1         <= st_now;
      cnt1        <= cnt_next_ext[ilid_pkg::POS_W-1:0];
      st2         <= st1;
      cnt2        <= cnt1;
      status      <= st2;
      entry_count <= cnt2;
    end
  end

  assign read_value = rd_data;

endmodule

@@ design/ilid_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_cell
// One list slot. Holds, loads, takes its lower neighbor on insert or its
// upper neighbor on delete, and registers its value as a read tap on a hit.
// ----------------------------------------------------------------------------
module ilid_cell #(
  parameter int IDX  = 0,
  parameter int PW   = 5
) (
  input  logic                       clk,
  input  logic                       adv,
  input  ilid_pkg::cmd_t             cmd,
  input  logic [PW-1:0]              pos,
  input  logic [ilid_pkg::DATA_W-1:0] lower,
  input  logic [ilid_pkg::DATA_W-1:0] upper,
  output logic [ilid_pkg::DATA_W-1:0] value,
  output logic [ilid_pkg::DATA_W-1:0] tap
);

  localparam logic [PW-1:0] HERE = PW'(IDX);

  logic [ilid_pkg::DATA_W-1:0] value_next;

  // Pick the slot's next content
  always_comb begin
    priority if (cmd.ins && (pos < HERE)) begin
      value_next = lower;
    end else if (cmd.ins && (pos == HERE)) begin
      value_next = cmd.value;
    end else if (cmd.del && (pos <= HERE)) begin
      value_next = upper;
    end else begin
      value_next = value;
    end
  end

  // Update slot and read tap
  always_ff @(posedge clk) begin
    if (adv) begin
      value <= value_next;
      tap   <= (cmd.rd && (pos == HERE)) ? value : '0;
    end
  end

endmodule

@@ design/ilid_or_tree.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_or_tree
// Two-level registered OR reduction of the cell read taps. At most one tap
// is nonzero, so the result is the value read, or zero.
// ----------------------------------------------------------------------------
module ilid_or_tree #(
  parameter int N = ilid_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                adv,
  input  logic [N-1:0][ilid_pkg::DATA_W-1:0]  taps,
  output logic [ilid_pkg::DATA_W-1:0]         result
);

  localparam int G  = ilid_pkg::TREE_GROUP;
  localparam int NG = (N + G - 1) / G;

  logic [NG-1:0][ilid_pkg::DATA_W-1:0] grp;
  logic [NG-1:0][ilid_pkg::DATA_W-1:0] grp_next;
  logic [ilid_pkg::DATA_W-1:0]         result_next;

  // Reduce each group of taps
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < G; k++) begin
        if (g * G + k < N) begin
          grp_next[g] = grp_next[g] | taps[g * G + k];
        end
      end
    end
  end

  // Reduce the group results
  always_comb begin
    result_next = '0;
    for (int g = 0; g < NG; g++) begin
      result_next = result_next | grp[g];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grp    <= grp_next;
      result <= result_next;
    end
  end

endmodule

@@ design/ilid_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_checker
// Port-level checks for the positional list block, bound to the top level.
// ----------------------------------------------------------------------------
module ilid_checker #(
  parameter int DEPTH = ilid_pkg::DEPTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_stall,
  input logic [ilid_pkg::OP_W-1:0]     operation,
  input logic [ilid_pkg::POS_W-1:0]    position,
  input logic [ilid_pkg::DATA_W-1:0]   item_value,
  input logic                          rsp_valid,
  input logic                          rsp_stall,
  input logic [ilid_pkg::ST_W-1:0]     status,
  input logic [ilid_pkg::DATA_W-1:0]   read_value,
  input logic [ilid_pkg::POS_W-1:0]    entry_count
);

  localparam logic [ilid_pkg::POS_W-1:0] FULL_SHOWN = ilid_pkg::POS_W'(DEPTH);

  // Result held while stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) &&
      $stable(read_value) && $stable(entry_count))
    else $error("result changed while stalled");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // A refused insert on a full list reports the full count
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ilid_pkg::ST_FULL) |-> entry_count == FULL_SHOWN)
    else $error("full status with count below capacity");

  // An empty list reports zero entries
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ilid_pkg::ST_EMPTY) |-> entry_count == '0)
    else $error("empty status with nonzero count");

  // Failed operations return no data
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ilid_pkg::ST_OK) |-> read_value == '0)
    else $error("nonzero read value on failed operation");

endmodule

bind indexed_list_insert_delete_get ilid_checker #(.DEPTH(DEPTH)) u_ilid_checker (.*);
